### hdl/nfa_pkg.sv
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared constants, types and codes for the automaton stepping block.
// ----------------------------------------------------------------------------
package nfa_pkg;

  localparam int unsigned NUM_STATES  = 16;
  localparam int unsigned MAX_EDGES   = 64;
  localparam int unsigned SYMBOL_BITS = 8;

  localparam int unsigned STATE_W = $clog2(NUM_STATES);
  localparam int unsigned EDGE_AW = $clog2(MAX_EDGES);
  localparam int unsigned EDGE_CW = $clog2(MAX_EDGES + 1);

  localparam logic CFG_START_MASK  = 1'b0;
  localparam logic CFG_ACCEPT_MASK = 1'b1;

  typedef logic [NUM_STATES-1:0] svec_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] label;
    logic [STATE_W-1:0]     src;
    logic [STATE_W-1:0]     dst;
  } edge_t;

  typedef enum logic [1:0] {
    KIND_ADD_EDGE  = 2'd0,
    KIND_ADD_EMPTY = 2'd1,
    KIND_RESTART   = 2'd2,
    KIND_STEP      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NO_START = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CLOSE,
    S_EPS_RD,
    S_EPS_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               wr_en;
    logic [EDGE_AW-1:0] wr_addr;
    edge_t              wr_data;
    logic               rd_en;
    logic [EDGE_AW-1:0] rd_addr;
  } edge_req_t;

  typedef struct packed {
    logic               wr_en;
    logic [STATE_W-1:0] wr_addr;
    svec_t              wr_data;
    logic               rd_en;
    logic [STATE_W-1:0] rd_addr;
  } row_req_t;

  typedef struct packed {
    svec_t   active_set;
    logic    any_active;
    logic    accepting;
    status_e status;
  } result_t;

endpackage

### hdl/nfa_edge_ram.sv
// ----------------------------------------------------------------------------
// nfa_edge_ram
// Symbol edge table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfa_edge_ram import nfa_pkg::*; (
  input  logic      clk_i,
  input  edge_req_t req_i,
  output edge_t     rd_data_o
);

  edge_t mem_q [MAX_EDGES];
  edge_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/nfa_eps_ram.sv
// ----------------------------------------------------------------------------
// nfa_eps_ram
// Empty-move rows, one per state, with per-row valid bits cleared at reset.
// ----------------------------------------------------------------------------
module nfa_eps_ram import nfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  row_req_t req_i,
  output svec_t    rd_data_o
);

  svec_t                 mem_q [NUM_STATES];
  svec_t                 rd_data_q;
  logic [NUM_STATES-1:0] valid_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  // unwritten rows read as no empty moves
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

### hdl/nfa_ctrl.sv
// ----------------------------------------------------------------------------
// nfa_ctrl
// Sequencer: edge walk over the edge table, sweeps over the empty-move rows
// until the active set stops growing, row read-modify-write for new moves.
// ----------------------------------------------------------------------------
module nfa_ctrl import nfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic [STATE_W-1:0]     src_i,
  input  logic [STATE_W-1:0]     dst_i,
  input  logic [SYMBOL_BITS-1:0] sym_i,
  input  svec_t                  start_mask_i,
  input  svec_t                  accept_mask_i,
  output edge_req_t              edge_req_o,
  input  edge_t                  edge_rd_i,
  output row_req_t               row_req_o,
  input  svec_t                  row_rd_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output result_t                res_o
);

  localparam logic [STATE_W-1:0] LAST_ROW = STATE_W'(NUM_STATES - 1);
  localparam logic [EDGE_CW-1:0] EDGE_MAX = EDGE_CW'(MAX_EDGES);

  state_e                 state_q, state_d;
  kind_e                  kind_q, kind_d;
  logic [STATE_W-1:0]     src_q, src_d;
  logic [STATE_W-1:0]     dst_q, dst_d;
  logic [SYMBOL_BITS-1:0] sym_q, sym_d;
  status_e                status_q, status_d;
  svec_t                  active_q, active_d;
  svec_t                  work_q, work_d;
  logic [EDGE_CW-1:0]     edge_cnt_q, edge_cnt_d;
  logic [EDGE_CW-1:0]     idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic [STATE_W-1:0]     pend_idx_q, pend_idx_d;
  logic [STATE_W-1:0]     row_j_q, row_j_d;
  logic                   issue_q, issue_d;
  logic                   chg_q, chg_d;

  logic  accept;
  logic  table_full;
  logic  walk_end;
  logic  grow;
  logic  chg_any;
  logic  sweep_end;
  kind_e kind_in;

  assign kind_in    = kind_e'(kind_i);
  assign accept     = in_valid_i && in_ready_o;
  assign table_full = (edge_cnt_q == EDGE_MAX);
  assign walk_end   = (idx_q == edge_cnt_q) && !pend_q;
  assign grow       = pend_q && work_q[pend_idx_q] && ((row_rd_i & ~work_q) != '0);
  assign chg_any    = chg_q || grow;
  assign sweep_end  = !issue_q && pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_in)
            KIND_ADD_EDGE:  state_d = S_DONE;
            KIND_ADD_EMPTY: state_d = S_EPS_RD;
            KIND_RESTART:   state_d = (start_mask_i == '0) ? S_DONE : S_CLOSE;
            KIND_STEP:      state_d = S_WALK;
            default:        state_d = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        if (walk_end) state_d = S_CLOSE;
      end
      S_CLOSE: begin
        if (sweep_end && !chg_any) state_d = S_DONE;
      end
      S_EPS_RD: state_d = S_EPS_WR;
      S_EPS_WR: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);

    edge_req_o.wr_en   = (state_q == S_IDLE) && in_valid_i &&
                         (kind_in == KIND_ADD_EDGE) && !table_full;
    edge_req_o.wr_addr = edge_cnt_q[EDGE_AW-1:0];
    edge_req_o.wr_data = '{label: sym_i, src: src_i, dst: dst_i};
    edge_req_o.rd_en   = (state_q == S_WALK) && (idx_q != edge_cnt_q);
    edge_req_o.rd_addr = idx_q[EDGE_AW-1:0];

    row_req_o.rd_en   = (state_q == S_EPS_RD) || ((state_q == S_CLOSE) && issue_q);
    row_req_o.rd_addr = (state_q == S_EPS_RD) ? src_q : row_j_q;
    row_req_o.wr_en   = (state_q == S_EPS_WR);
    row_req_o.wr_addr = src_q;
    row_req_o.wr_data = row_rd_i | (svec_t'(1) << dst_q);

    res_o.active_set = active_q;
    res_o.any_active = (active_q != '0);
    res_o.accepting  = ((active_q & accept_mask_i) != '0);
    res_o.status     = status_q;
  end

  // datapath
  always_comb begin
    kind_d     = kind_q;
    src_d      = src_q;
    dst_d      = dst_q;
    sym_d      = sym_q;
    status_d   = status_q;
    active_d   = active_q;
    work_d     = work_q;
    edge_cnt_d = edge_cnt_q;
    idx_d      = idx_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    row_j_d    = row_j_q;
    issue_d    = issue_q;
    chg_d      = chg_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = kind_in;
          src_d    = src_i;
          dst_d    = dst_i;
          sym_d    = sym_i;
          status_d = STS_OK;
          case (kind_in)
            KIND_ADD_EDGE: begin
              if (table_full) status_d = STS_FULL;
              else edge_cnt_d = edge_cnt_q + 1'b1;
            end
            KIND_RESTART: begin
              if (start_mask_i == '0) begin
                status_d = STS_NO_START;
              end else begin
                work_d  = start_mask_i;
                row_j_d = '0;
                issue_d = 1'b1;
                chg_d   = 1'b0;
              end
            end
            KIND_STEP: begin
              work_d = '0;
              idx_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (edge_req_o.rd_en) begin
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q && (edge_rd_i.label == sym_q) && active_q[edge_rd_i.src]) begin
          work_d = work_q | (svec_t'(1) << edge_rd_i.dst);
        end
        if (walk_end) begin
          row_j_d = '0;
          issue_d = 1'b1;
          chg_d   = 1'b0;
        end
      end
      S_CLOSE: begin
        if (issue_q) begin
          pend_d     = 1'b1;
          pend_idx_d = row_j_q;
          row_j_d    = row_j_q + 1'b1;
          if (row_j_q == LAST_ROW) issue_d = 1'b0;
        end
        if (grow) work_d = work_q | row_rd_i;
        chg_d = chg_any;
        if (sweep_end) begin
          if (chg_any) begin
            issue_d = 1'b1;
            row_j_d = '0;
            chg_d   = 1'b0;
          end else begin
            active_d = work_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      edge_cnt_q <= '0;
      active_q   <= '0;
      pend_q     <= 1'b0;
      issue_q    <= 1'b0;
      chg_q      <= 1'b0;
      status_q   <= STS_OK;
    end else begin
      state_q    <= state_d;
      edge_cnt_q <= edge_cnt_d;
      active_q   <= active_d;
      pend_q     <= pend_d;
      issue_q    <= issue_d;
      chg_q      <= chg_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    sym_q      <= sym_d;
    work_q     <= work_d;
    idx_q      <= idx_d;
    pend_idx_q <= pend_idx_d;
    row_j_q    <= row_j_d;
  end

endmodule

### hdl/nfa_step_with_epsilon_closure.sv
// ----------------------------------------------------------------------------
// nfa_step_with_epsilon_closure
// Automaton with empty moves, stepped one word at a time.
//
// Input channel (in_valid_i/in_ready_o) carries one word per command: add a
// symbol edge, add an empty-move edge, restart, or consume a symbol. Each
// word yields exactly one result word on the output channel
// (out_valid_o/out_ready_i). start_mask and accept_mask are written over the
// APB port (offsets 0x0 and 0x4); pready is tied high.
// One word at a time: in_ready_o drops after an accept and returns once the
// result is handed to the output register.
//   add symbol edge : table write, then result handoff
//   add empty move  : row read, modify, write back
//   restart / step  : step walks the edge table, one read per stored
//                     edge; then sweeps over the 16 empty-move rows,
//                     repeated until a sweep adds nothing (at most 16),
//                     then the result handoff.
// Reset empties the edge table and the empty-move rows and clears the
// active set and both masks. A stalled output holds its word; the next
// input word is still taken and its result waits in the sequencer.
// ----------------------------------------------------------------------------
module nfa_step_with_epsilon_closure import nfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic [STATE_W-1:0]     source_state_i,
  input  logic [STATE_W-1:0]     target_state_i,
  input  logic [SYMBOL_BITS-1:0] symbol_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output svec_t                  active_set_o,
  output logic                   any_active_o,
  output logic                   accepting_o,
  output logic [1:0]             status_o
);

  svec_t     start_q, accept_q;
  logic      cfg_wr;
  edge_req_t edge_req;
  edge_t     edge_rd;
  row_req_t  row_req;
  svec_t     row_rd;
  logic      res_valid, res_ready;
  result_t   res;
  logic      out_valid_q;
  result_t   out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CFG_ACCEPT_MASK) ? 32'(accept_q) : 32'(start_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      accept_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_START_MASK) start_q <= pwdata[NUM_STATES-1:0];
      else accept_q <= pwdata[NUM_STATES-1:0];
    end
  end

  nfa_edge_ram u_edge_ram (
    .clk_i     (clk_i),
    .req_i     (edge_req),
    .rd_data_o (edge_rd)
  );

  nfa_eps_ram u_eps_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (row_req),
    .rd_data_o (row_rd)
  );

  nfa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .src_i         (source_state_i),
    .dst_i         (target_state_i),
    .sym_i         (symbol_i),
    .start_mask_i  (start_q),
    .accept_mask_i (accept_q),
    .edge_req_o    (edge_req),
    .edge_rd_i     (edge_rd),
    .row_req_o     (row_req),
    .row_rd_i      (row_rd),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign active_set_o = out_q.active_set;
  assign any_active_o = out_q.any_active;
  assign accepting_o  = out_q.accepting;
  assign status_o     = out_q.status;

endmodule

### hdl/nfa_checker.sv
// ----------------------------------------------------------------------------
// nfa_checker
// Port-level checks on the automaton stepping block, bound to the top level.
// ----------------------------------------------------------------------------
module nfa_checker import nfa_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input svec_t                  active_set_o,
  input logic                   any_active_o,
  input logic                   accepting_o,
  input logic [1:0]             status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(active_set_o) &&
    $stable(status_o))
    else $error("result word changed while stalled");

  a_any_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (any_active_o == (active_set_o != '0)))
    else $error("any_active disagrees with active_set");

  a_accepting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepting_o |-> any_active_o)
    else $error("accepting with empty active set");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STS_OK || status_o == STS_FULL ||
                     status_o == STS_NO_START))
    else $error("undefined status code");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in progress");

endmodule

bind nfa_step_with_epsilon_closure nfa_checker u_nfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .active_set_o (active_set_o),
  .any_active_o (any_active_o),
  .accepting_o  (accepting_o),
  .status_o     (status_o)
);

### tb/sv/nfa_step_with_epsilon_closure_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nfa_step_with_epsilon_closure_tb
// Self-checking bench for the automaton stepping block. A directed table
// covers reset values, an empty edge table, duplicate edges, dead steps and
// restarts with and without start states. Random command words follow over
// several mask settings, PHASE_WORDS words per setting. Every result word is
// compared against an in-bench copy of the automaton, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module nfa_step_with_epsilon_closure_tb;
  import nfa_pkg::*;

  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 232;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 400;

  localparam result_t NIL = '{16'h0000, 1'b0, 1'b0, STS_OK};

  typedef struct {
    bit                     is_reg;
    logic                   reg_sel;
    svec_t                  reg_val;
    kind_e                  kind;
    logic [STATE_W-1:0]     src;
    logic [STATE_W-1:0]     dst;
    logic [SYMBOL_BITS-1:0] sym;
    bit                     typed;
    result_t                want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [2:0]             paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             kind_i;
  logic [STATE_W-1:0]     source_state_i;
  logic [STATE_W-1:0]     target_state_i;
  logic [SYMBOL_BITS-1:0] symbol_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  svec_t                  active_set_o;
  logic                   any_active_o;
  logic                   accepting_o;
  logic [1:0]             status_o;

  edge_t       edge_mem [MAX_EDGES];
  int unsigned edge_total;
  svec_t       empty_rows [NUM_STATES];
  svec_t       live_set;
  svec_t       start_reg;
  svec_t       accept_reg;

  result_t     predicted_reports [$];
  bit          no_stall;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned reports_seen;
  int unsigned dropped_edges;
  int unsigned failed_restarts;
  int unsigned empty_sent;
  int unsigned reg_writes;
  int unsigned idle_cycles;

  logic [SYMBOL_BITS-1:0] sym_pool [4];
  plan_row_t              plan [25];

  nfa_step_with_epsilon_closure u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .source_state_i (source_state_i),
    .target_state_i (target_state_i),
    .symbol_i       (symbol_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .active_set_o   (active_set_o),
    .any_active_o   (any_active_o),
    .accepting_o    (accepting_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic svec_t close_empty_moves(input svec_t seed);
    svec_t cur;
    svec_t grown;
    cur = seed;
    for (int r = 0; r <= NUM_STATES; r++) begin
      grown = cur;
      for (int s = 0; s < NUM_STATES; s++)
        if (cur[s]) grown |= empty_rows[s];
      if (grown == cur) break;
      cur = grown;
    end
    return cur;
  endfunction

  function automatic result_t advance_automaton(input kind_e k,
                                                input logic [STATE_W-1:0] s,
                                                input logic [STATE_W-1:0] d,
                                                input logic [SYMBOL_BITS-1:0] y);
    result_t r;
    svec_t   reached;
    r.status = STS_OK;
    case (k)
      KIND_ADD_EDGE: begin
        if (edge_total < MAX_EDGES) begin
          edge_mem[edge_total] = '{label: y, src: s, dst: d};
          edge_total++;
        end else begin
          r.status = STS_FULL;
        end
      end
      KIND_ADD_EMPTY: begin
        empty_rows[s][d] = 1'b1;
      end
      KIND_RESTART: begin
        if (start_reg == '0) r.status = STS_NO_START;
        else live_set = close_empty_moves(start_reg);
      end
      default: begin
        reached = '0;
        for (int i = 0; i < edge_total; i++)
          if (edge_mem[i].label == y && live_set[edge_mem[i].src])
            reached[edge_mem[i].dst] = 1'b1;
        live_set = close_empty_moves(reached);
      end
    endcase
    r.active_set = live_set;
    r.any_active = |live_set;
    r.accepting  = |(live_set & accept_reg);
    return r;
  endfunction

  function automatic plan_row_t word_row(input kind_e k, input int s, input int d,
                                         input logic [SYMBOL_BITS-1:0] y,
                                         input bit typed, input result_t want);
    return '{1'b0, CFG_START_MASK, '0, k, s[STATE_W-1:0], d[STATE_W-1:0], y, typed,
             want};
  endfunction

  function automatic plan_row_t reg_row(input logic sel, input svec_t val);
    return '{1'b1, sel, val, KIND_STEP, '0, '0, '0, 1'b0, NIL};
  endfunction

  // Enter and leave at a falling edge.
  task automatic send_word(input kind_e k, input logic [STATE_W-1:0] s,
                           input logic [STATE_W-1:0] d,
                           input logic [SYMBOL_BITS-1:0] y,
                           input bit typed, input result_t want);
    result_t pred;
    if (!no_stall && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 11);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    source_state_i <= s;
    target_state_i <= d;
    symbol_i       <= y;
    do @(posedge clk_i); while (!in_ready_o);
    pred = advance_automaton(k, s, d, y);
    if (pred.status == STS_FULL) dropped_edges++;
    if (pred.status == STS_NO_START) failed_restarts++;
    predicted_reports.insert(predicted_reports.size(), typed ? want : pred);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    int unsigned roll;
    int unsigned eps_pct;
    kind_e       k;
    logic [STATE_W-1:0]     s;
    logic [STATE_W-1:0]     d;
    logic [SYMBOL_BITS-1:0] y;
    roll    = $urandom_range(99);
    eps_pct = (empty_sent < 20) ? 6 : 1;
    s       = STATE_W'($urandom_range(NUM_STATES - 1));
    d       = STATE_W'($urandom_range(NUM_STATES - 1));
    y       = ($urandom_range(99) < 85) ? sym_pool[2'($urandom_range(3))] :
                                          SYMBOL_BITS'($urandom);
    if (roll < 15) k = KIND_ADD_EDGE;
    else if (roll < 15 + eps_pct) k = KIND_ADD_EMPTY;
    else if (roll < 27 + eps_pct) k = KIND_RESTART;
    else k = KIND_STEP;
    if (k == KIND_ADD_EMPTY) empty_sent++;
    send_word(k, s, d, y, 1'b0, NIL);
  endtask

  // Drop valid and wait until every result word is back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic sel, input svec_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == CFG_START_MASK) start_reg = val;
    else accept_reg = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[NUM_STATES-1:0] !== val) begin
      mismatches++;
      $display("%0t: register %0d readback expected %h actual %h",
               $time, sel, val, prdata[NUM_STATES-1:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_seen++;
      if (predicted_reports.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result word, actual active_set=%h status=%0d",
                 $time, active_set_o, status_o);
      end else begin
        want = predicted_reports.pop_front();
        if (active_set_o !== want.active_set || any_active_o !== want.any_active ||
            accepting_o !== want.accepting || status_o !== want.status) begin
          mismatches++;
          $display({"%0t: expected active_set=%h any=%b acc=%b status=%0d, ",
                    "actual active_set=%h any=%b acc=%b status=%0d"},
                   $time, want.active_set, want.any_active, want.accepting,
                   want.status, active_set_o, any_active_o, accepting_o, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    svec_t st;
    svec_t ac;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_ADD_EDGE;
    source_state_i = '0;
    target_state_i = '0;
    symbol_i       = '0;
    no_stall       = 1'b0;
    edge_total     = 0;
    live_set       = '0;
    start_reg      = '0;
    accept_reg     = '0;
    foreach (empty_rows[i]) empty_rows[i] = '0;
    foreach (sym_pool[i]) sym_pool[i] = SYMBOL_BITS'($urandom);

    plan = '{
      word_row(KIND_RESTART,    0,  0, 8'h00, 1'b1, '{16'h0000, 1'b0, 1'b0, STS_NO_START}),
      word_row(KIND_STEP,       0,  0, 8'h00, 1'b1, NIL),
      word_row(KIND_ADD_EDGE,   0, 15, 8'hFF, 1'b1, NIL),
      word_row(KIND_ADD_EDGE,  15,  0, 8'h00, 1'b1, NIL),
      word_row(KIND_ADD_EDGE,   0,  1, 8'hA5, 1'b1, NIL),
      word_row(KIND_ADD_EMPTY,  1,  2, 8'h00, 1'b1, NIL),
      word_row(KIND_ADD_EMPTY,  2,  3, 8'h00, 1'b1, NIL),
      word_row(KIND_ADD_EMPTY,  3,  3, 8'h00, 1'b1, NIL),
      word_row(KIND_ADD_EMPTY, 15, 14, 8'h00, 1'b1, NIL),
      reg_row(CFG_START_MASK,  16'h0001),
      reg_row(CFG_ACCEPT_MASK, 16'h8008),
      word_row(KIND_RESTART,    0,  0, 8'h00, 1'b1, '{16'h0001, 1'b1, 1'b0, STS_OK}),
      word_row(KIND_STEP,       0,  0, 8'hA5, 1'b0, NIL),
      word_row(KIND_STEP,       0,  0, 8'h00, 1'b1, NIL),
      word_row(KIND_RESTART,    0,  0, 8'h00, 1'b0, NIL),
      word_row(KIND_STEP,       0,  0, 8'hFF, 1'b0, NIL),
      word_row(KIND_STEP,       0,  0, 8'h00, 1'b0, NIL),
      word_row(KIND_ADD_EDGE,   0,  1, 8'hA5, 1'b0, NIL),
      word_row(KIND_STEP,       0,  0, 8'hA5, 1'b0, NIL),
      word_row(KIND_ADD_EDGE,  10,  5, 8'h5A, 1'b0, NIL),
      reg_row(CFG_START_MASK,  16'hFFFF),
      reg_row(CFG_ACCEPT_MASK, 16'h0000),
      word_row(KIND_RESTART,    0,  0, 8'h00, 1'b1, '{16'hFFFF, 1'b1, 1'b0, STS_OK}),
      word_row(KIND_STEP,       0,  0, 8'h5A, 1'b0, NIL),
      word_row(KIND_ADD_EMPTY,  0, 15, 8'h00, 1'b0, NIL)
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        send_word(plan[i].kind, plan[i].src, plan[i].dst, plan[i].sym,
                  plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          st = svec_t'($urandom_range(16'hFFFF, 1));
          ac = svec_t'($urandom);
        end
        1: begin
          st = 16'h0001;
          ac = 16'hFFFF;
        end
        2: begin
          st = 16'h0000;
          ac = 16'h0000;
        end
        3: begin
          st = 16'hFFFF;
          ac = svec_t'($urandom);
        end
        4: begin
          st = 16'h8000;
          ac = 16'h0001;
        end
        default: begin
          st = (svec_t'(1) << $urandom_range(NUM_STATES - 1)) |
               (svec_t'(1) << $urandom_range(NUM_STATES - 1));
          ac = svec_t'($urandom);
        end
      endcase
      write_reg(CFG_START_MASK, st);
      write_reg(CFG_ACCEPT_MASK, ac);
      no_stall = (ph == 3);
      repeat (PHASE_WORDS) send_random_word();
    end

    in_valid_i <= 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Sent %0d command words, checked %0d result words, %0d register writes",
             words_sent, reports_seen, reg_writes);
    $display("Edges dropped on a full table: %0d, restarts with no start state: %0d",
             dropped_edges, failed_restarts);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
